FILE: rtl/spfe_pkg.sv
`timescale 1ns / 1ps
package spfe_pkg;

	localparam int IN_W       = 24;
	localparam int OUT_W      = 24;
	localparam int TEMP_W     = 11;
	localparam int HUM_W      = 10;
	localparam int TIME_W     = 11;
	localparam int ADDR_W     = 3;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 3;
	localparam int FRAME_W    = 62;
	localparam int LEN_W      = 6;
	localparam int NIB_N      = 10;
	localparam int DATA_W     = NIB_N * 5;
	localparam int Q_DEPTH    = 2;
	localparam int Q_PTR_W    = $clog2(Q_DEPTH);
	localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] REG_PROTOCOL = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ADDRESS  = 1'd1;

	localparam logic [TIME_W-1:0] SHORT_V11  = 11'd610;
	localparam logic [TIME_W-1:0] LONG_V11   = 11'd1221;
	localparam logic [TIME_W-1:0] SHORT_V12  = 11'd366;
	localparam logic [TIME_W-1:0] LONG_V12   = 11'd854;
	localparam logic [TIME_W-1:0] PERIOD_V11 = 11'd1831;
	localparam logic [TIME_W-1:0] PERIOD_V12 = 11'd1220;
	localparam logic [LEN_W-1:0]  LEN_V11    = 6'd62;
	localparam logic [LEN_W-1:0]  LEN_V12    = 6'd61;
	localparam int                SYNC_V11   = 16;
	localparam int                SYNC_V12   = 10;
	localparam logic [3:0]        TYPE_NIB   = 4'h1;
	localparam logic [3:0]        SUM_BIAS   = 4'd5;
	localparam logic [17:0]       RECIP_10   = 18'd205;

	typedef struct packed {
		logic [FRAME_W-1:0] bits;
		logic               v12;
	} frame_t;

	// q <= 102: returns {hundreds digit, tens digit} of the original value (q = value / 10)
	function automatic logic [7:0] bcd_split(input logic [6:0] q);
		logic [3:0] hi;
		logic [6:0] rem;
		hi = 4'd0;
		for (int k = 1; k <= 10; k++) begin
			if (q >= 7'(k * 10)) hi = 4'(k);
		end
		rem = q - ({hi, 3'b000} + {2'b00, hi, 1'b0});
		bcd_split = {(hi == 4'd10) ? 4'd0 : hi, rem[3:0]};
	endfunction

endpackage

FILE: rtl/sensor_frame_pulse_encoder.sv
`timescale 1ns / 1ps
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tdata: temp_tenths, humidity_tenths
// m_*       out  m_tvalid/m_tready  tdata: bit_value, pulse_high_us, bit_period_us;
//                                   tlast: last_bit
// cfg_*     in   cfg_we             cfg_index, cfg_wdata
//
// A reading passes the front pipe registers s1, s2 and s3, then waits in a 2-entry frame queue.
// The serializer sends one symbol per cycle while m_tready is high: 61 (protocol 1.2) or 62
// (protocol 1.1) symbols per reading, frames back to back with no gap while the queue is not empty.
// Reset clears the registers to protocol 1.2, address 0, and empties queue and pipe.
// Output stalls hold the serializer; the front keeps taking readings until the queue fills.
module sensor_frame_pulse_encoder (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [10:0] temp_tenths, [20:11] humidity_tenths
	input  logic [spfe_pkg::IN_W-1:0]         s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [0] bit_value, [11:1] pulse_high_us, [22:12] bit_period_us
	output logic [spfe_pkg::OUT_W-1:0]        m_tdata,
	output logic                              m_tlast,
	input  logic                              cfg_we,
	input  logic [spfe_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [spfe_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
	import spfe_pkg::*;

	logic              prot_q;
	logic [ADDR_W-1:0] addr_q;
	logic              push, pop, q_full, q_empty;
	frame_t            push_frame, q_frame;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prot_q <= 1'b1;
			addr_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PROTOCOL: prot_q <= cfg_wdata[0];
				REG_ADDRESS:  addr_q <= cfg_wdata[ADDR_W-1:0];
				default: ;
			endcase
		end
	end

	spfe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.sel_v12    (prot_q),
		.addr       (addr_q),
		.push       (push),
		.push_frame (push_frame),
		.q_full     (q_full)
	);

	spfe_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_frame (push_frame),
		.full     (q_full),
		.pop      (pop),
		.rd_frame (q_frame),
		.empty    (q_empty)
	);

	spfe_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_frame  (q_frame),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_full && !pop))
		else $error("frame queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && q_empty))
		else $error("frame queue underflow");

	// every frame opens with a sync zero
	a_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> (!m_tvalid || !m_tdata[0]))
		else $error("frame does not start with sync zero");

	// the final symbol is always a stop one
	a_last_is_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> m_tdata[0])
		else $error("last symbol is not a stop bit");

endmodule

FILE: rtl/spfe_front.sv
`timescale 1ns / 1ps
module spfe_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [spfe_pkg::IN_W-1:0]     s_tdata,
	input  logic                          sel_v12,
	input  logic [spfe_pkg::ADDR_W-1:0]   addr,
	output logic                          push,
	output spfe_pkg::frame_t              push_frame,
	input  logic                          q_full
);
	import spfe_pkg::*;

	logic en;
	logic v_s1, v_s2, v_s3;

	logic [TEMP_W-1:0] traw;
	logic [HUM_W-1:0]  hraw;
	logic              neg;
	logic [TEMP_W-1:0] mag;
	logic [17:0]       tprod, hprod;

	logic [TEMP_W-1:0] tmag_s1;
	logic [HUM_W-1:0]  hum_s1;
	logic [6:0]        tq_s1, hq_s1;
	logic              neg_s1, v12_s1;
	logic [ADDR_W-1:0] addr_s1;

	logic [3:0] nib_s2 [8];
	logic       v12_s2;
	logic [TEMP_W-1:0] t10, h10;
	logic [7:0] tsplit, hsplit;
	logic [3:0] t0, h0;

	logic [3:0]         chk, sum;
	logic [DATA_W-1:0]  data;
	frame_t             frame_s3;

	assign en       = !v_s3 || !q_full;
	assign s_tready = en;
	assign push     = v_s3 && !q_full;
	assign push_frame = frame_s3;

	// stage 1: sign/magnitude and value/10 by reciprocal multiply
	assign traw  = s_tdata[TEMP_W-1:0];
	assign hraw  = s_tdata[TEMP_W +: HUM_W];
	assign neg   = traw[TEMP_W-1];
	assign mag   = neg ? (~traw + 11'd1) : traw;
	assign tprod = 18'(mag) * RECIP_10;
	assign hprod = 18'(hraw) * RECIP_10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tmag_s1 <= mag;
			hum_s1  <= hraw;
			tq_s1   <= tprod[17:11];
			hq_s1   <= hprod[17:11];
			neg_s1  <= neg;
			v12_s1  <= sel_v12;
			addr_s1 <= addr;
		end
	end

	// stage 2: BCD digits
	assign t10    = {1'b0, tq_s1, 3'b000} + {3'b000, tq_s1, 1'b0};
	assign h10    = {1'b0, hq_s1, 3'b000} + {3'b000, hq_s1, 1'b0};
	assign t0     = 4'(tmag_s1 - t10);
	assign h0     = 4'({1'b0, hum_s1} - h10);
	assign tsplit = bcd_split(tq_s1);
	assign hsplit = bcd_split(hq_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			nib_s2[0] <= TYPE_NIB;
			nib_s2[1] <= {neg_s1, addr_s1};
			nib_s2[2] <= t0;
			nib_s2[3] <= tsplit[3:0];
			nib_s2[4] <= tsplit[7:4];
			nib_s2[5] <= h0;
			nib_s2[6] <= hsplit[3:0];
			nib_s2[7] <= hsplit[7:4];
			v12_s2    <= v12_s1;
		end
	end

	// stage 3: check nibbles and the serial bit image, stop bit after each nibble (protocol 1.1 drops the sum nibble)
	always_comb begin
		chk = 4'd0;
		sum = 4'd0;
		for (int n = 0; n < 8; n++) begin
			chk = chk ^ nib_s2[n];
			sum = sum + nib_s2[n];
			data[n*5 +: 5] = {1'b1, nib_s2[n]};
		end
		data[40 +: 5] = {1'b1, chk};
		data[45 +: 5] = {1'b1, sum + chk + SUM_BIAS};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			frame_s3.v12 <= v12_s2;
			if (v12_s2)
				frame_s3.bits <= {1'b0, data, 1'b1, {SYNC_V12{1'b0}}};
			else
				frame_s3.bits <= {data[44:0], 1'b1, {SYNC_V11{1'b0}}};
		end
	end

endmodule

FILE: rtl/spfe_fifo.sv
`timescale 1ns / 1ps
module spfe_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  spfe_pkg::frame_t wr_frame,
	output logic             full,
	input  logic             pop,
	output spfe_pkg::frame_t rd_frame,
	output logic             empty
);
	import spfe_pkg::*;

	frame_t              mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]  wp_q, rp_q;
	logic [Q_CNT_W-1:0]  cnt_q;

	assign full     = cnt_q == Q_CNT_W'(Q_DEPTH);
	assign empty    = cnt_q == '0;
	assign rd_frame = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop)  rp_q <= rp_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_frame;
	end

endmodule

FILE: rtl/spfe_back.sv
`timescale 1ns / 1ps
module spfe_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_empty,
	input  spfe_pkg::frame_t            q_frame,
	output logic                        pop,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [spfe_pkg::OUT_W-1:0]  m_tdata,
	output logic                        m_tlast
);
	import spfe_pkg::*;

	logic [FRAME_W-1:0] sh_q;
	logic [LEN_W-1:0]   cnt_q;
	logic               v12_q;
	logic               hs;
	logic               bitv;
	logic [TIME_W-1:0]  high_t, period_t;

	assign hs       = m_tvalid && m_tready;
	assign m_tvalid = cnt_q != '0;
	assign pop      = !q_empty && (cnt_q == '0 || (cnt_q == LEN_W'(1) && hs));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (pop) begin
			cnt_q <= q_frame.v12 ? LEN_V12 : LEN_V11;
		end else if (hs) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			sh_q  <= q_frame.bits;
			v12_q <= q_frame.v12;
		end else if (hs) begin
			sh_q <= {1'b0, sh_q[FRAME_W-1:1]};
		end
	end

	assign bitv     = sh_q[0];
	assign high_t   = v12_q ? (bitv ? SHORT_V12 : LONG_V12) : (bitv ? SHORT_V11 : LONG_V11);
	assign period_t = v12_q ? PERIOD_V12 : PERIOD_V11;
	assign m_tdata  = {1'b0, period_t, high_t, bitv};
	assign m_tlast  = cnt_q == LEN_W'(1);

endmodule
